@@ design/bole_pkg.sv @@
// Shared types and constants for the bounded ordered list engine.
package bole_pkg;

    localparam int DEFAULT_LIST_DEPTH = 16;
    localparam int VALUE_W            = 32;
    localparam int IDX_W              = 4;
    localparam int COUNT_OUT_W        = 5;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_INSERT     = 2'd1,
        CMD_DELETE     = 2'd2,
        CMD_SEARCH     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef enum logic {
        SHIFT_OPEN  = 1'b0,
        SHIFT_CLOSE = 1'b1
    } shift_t;

    typedef struct packed {
        cmd_t                       cmd;
        logic signed [VALUE_W-1:0]  value;
    } cmd_item_t;

    typedef struct packed {
        status_t                    status;
        logic [IDX_W-1:0]           match_index;
        logic [COUNT_OUT_W-1:0]     entry_count;
        logic                       is_empty;
    } rsp_item_t;

    typedef struct packed {
        logic                       compare;
        logic                       update;
        shift_t                     shift;
        logic signed [VALUE_W-1:0]  value;
    } cell_ctrl_t;

endpackage

@@ design/bole_cell.sv @@
// One list position: holds an entry, compares it and takes data from a neighbor.
module bole_cell #(
    parameter int LIST_DEPTH = bole_pkg::DEFAULT_LIST_DEPTH,
    parameter int INDEX      = 0,
    parameter int POS_W      = $clog2(LIST_DEPTH)
) (
    input  logic                                 clk,
    input  bole_pkg::cell_ctrl_t                 ctrl,
    input  logic [POS_W-1:0]                     pos,
    input  logic signed [bole_pkg::VALUE_W-1:0]  prev_entry,
    input  logic signed [bole_pkg::VALUE_W-1:0]  next_entry,
    output logic signed [bole_pkg::VALUE_W-1:0]  entry,
    output logic                                 ge,
    output logic                                 eq
);
    import bole_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;
    logic                      ge_reg;
    logic                      ge_next;
    logic                      eq_reg;
    logic                      eq_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.update)
        begin
            case (ctrl.shift)
                SHIFT_OPEN:
                begin
                    if (MY_POS > pos)
                    begin
                        entry_next = prev_entry;
                    end
                    else if (MY_POS == pos)
                    begin
                        entry_next = $signed(ctrl.value);
                    end
                end
                SHIFT_CLOSE:
                begin
                    if (MY_POS >= pos)
                    begin
                        entry_next = next_entry;
                    end
                end
                default:
                begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        ge_next = ge_reg;
        eq_next = eq_reg;
        if (ctrl.compare)
        begin
            ge_next = (entry_reg >= $signed(ctrl.value));
            eq_next = (entry_reg == $signed(ctrl.value));
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        ge_reg    <= ge_next;
        eq_reg    <= eq_next;
    end

    assign entry = entry_reg;
    assign ge    = ge_reg;
    assign eq    = eq_reg;

endmodule

@@ design/bounded_ordered_list_engine_core.sv @@
// Top level of the bounded ordered list engine: command sequencer and row of list cells.
//
//  Channel   Signals                         Direction   Carries
//  command   cmd_valid, cmd_stall, cmd_data  in          operation and value
//  response  rsp_valid, rsp_stall, rsp_data  out         status, index, count, empty flag
//
// Push front goes through the update state to the response; an insert into a full list goes
// straight to the response. Ordered insert and a delete that hits pass through compare, scan,
// update and done; search or a miss through compare, scan and done. The scan stops at a hit or
// at the entry count, and the command channel is free again when the response is loaded. After reset the list is empty.
// A stalled response holds the result while the next transaction is accepted; that
// transaction completes once the response register is free.
module bounded_ordered_list_engine_core #(
    parameter int LIST_DEPTH = bole_pkg::DEFAULT_LIST_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  bole_pkg::cmd_item_t  cmd_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output bole_pkg::rsp_item_t  rsp_data
);
    import bole_pkg::*;

    localparam int POS_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_COMPARE = 5'b00010,
        S_SCAN    = 5'b00100,
        S_UPDATE  = 5'b01000,
        S_DONE    = 5'b10000
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    cmd_t                      cmd_reg;
    cmd_t                      cmd_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic [CNT_W-1:0]          scan_reg;
    logic [CNT_W-1:0]          scan_next;
    logic [POS_W-1:0]          pos_reg;
    logic [POS_W-1:0]          pos_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    rsp_item_t                 rsp_data_reg;
    rsp_item_t                 rsp_data_next;

    logic signed [VALUE_W-1:0] entry   [LIST_DEPTH];
    logic signed [VALUE_W-1:0] prev_in [LIST_DEPTH];
    logic signed [VALUE_W-1:0] next_in [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]     ge_vec;
    logic [LIST_DEPTH-1:0]     eq_vec;
    cell_ctrl_t                cell_ctrl;

    logic is_insert;
    logic full;
    logic hit;
    logic rsp_free;

    assign is_insert = (cmd_reg == CMD_PUSH_FRONT) || (cmd_reg == CMD_INSERT);
    assign full      = (count_reg == CNT_W'(LIST_DEPTH));
    assign hit       = (cmd_reg == CMD_INSERT) ? ge_vec[scan_reg[POS_W-1:0]]
                                               : eq_vec[scan_reg[POS_W-1:0]];
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        cell_ctrl.compare = (state_reg == S_COMPARE);
        cell_ctrl.update  = (state_reg == S_UPDATE);
        cell_ctrl.shift   = is_insert ? SHIFT_OPEN : SHIFT_CLOSE;
        cell_ctrl.value   = value_reg;
    end

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign prev_in[i] = value_reg;
        end
        else
        begin : g_body
            assign prev_in[i] = entry[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_tail
            assign next_in[i] = entry[i];
        end
        else
        begin : g_link
            assign next_in[i] = entry[i+1];
        end

        bole_cell #(
            .LIST_DEPTH (LIST_DEPTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .pos        (pos_reg),
            .prev_entry (prev_in[i]),
            .next_entry (next_in[i]),
            .entry      (entry[i]),
            .ge         (ge_vec[i]),
            .eq         (eq_vec[i])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        value_next     = value_reg;
        scan_next      = scan_reg;
        pos_next       = pos_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd_data.cmd;
                    value_next  = cmd_data.value;
                    scan_next   = '0;
                    pos_next    = '0;
                    status_next = STATUS_OK;
                    unique case (cmd_data.cmd) inside
                        CMD_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_UPDATE;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_COMPARE;
                            end
                        end
                        CMD_DELETE, CMD_SEARCH:
                        begin
                            state_next = S_COMPARE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_COMPARE:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_reg == count_reg)
                begin
                    if (is_insert)
                    begin
                        pos_next   = scan_reg[POS_W-1:0];
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        status_next = STATUS_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                end
                else if (hit)
                begin
                    pos_next   = scan_reg[POS_W-1:0];
                    state_next = (cmd_reg == CMD_SEARCH) ? S_DONE : S_UPDATE;
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            S_UPDATE:
            begin
                count_next = is_insert ? (count_reg + CNT_W'(1)) : (count_reg - CNT_W'(1));
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_data_next.status       = status_reg;
                    rsp_data_next.match_index  = (!is_insert && status_reg == STATUS_OK)
                                                 ? IDX_W'(pos_reg) : '0;
                    rsp_data_next.entry_count  = COUNT_OUT_W'(count_reg);
                    rsp_data_next.is_empty     = (count_reg == '0);
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        value_reg    <= value_next;
        scan_reg     <= scan_next;
        pos_reg      <= pos_next;
        status_reg   <= status_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("Entry count exceeds the list depth.");

    a_accept_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> $stable(count_reg))
        else $error("Entry count changed in the cycle after a transaction.");

    a_full_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.status == STATUS_FULL)
        |-> (rsp_data.entry_count == COUNT_OUT_W'(LIST_DEPTH)))
        else $error("Full status reported with a list that is not full.");

    a_not_found_index: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.status == STATUS_NOT_FOUND) |-> (rsp_data.match_index == '0))
        else $error("Not-found response carries a nonzero index.");

endmodule
